>>> rtl/lesf_pkg.sv
package lesf_pkg;

  localparam int unsigned MaxCols = 1024;
  localparam int unsigned MaxRows = 65536;

  localparam int unsigned ColW  = $clog2(MaxCols);
  localparam int unsigned RowW  = $clog2(MaxRows);
  localparam int unsigned SizeW = ColW + 1;
  localparam int unsigned LenW  = ColW + 1;
  localparam int unsigned CntW  = RowW + 1;
  localparam int unsigned CharW = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = CntW;

  localparam logic [LenW-1:0] LenReset = LenW'(MaxCols);
  localparam logic [CntW-1:0] CntReset = CntW'(1);
  localparam logic [CharW-1:0] ObstacleReset = 8'd111;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEmptyChar    = 2'd0,
    CfgObstacleChar = 2'd1,
    CfgRowLength    = 2'd2,
    CfgRowCount     = 2'd3
  } cfg_index_t;

endpackage

>>> rtl/largest_empty_square_finder_top.sv
// channel  direction  handshake                 payload
// in       input      in_valid / in_ready       cell_char
// out      output     out_valid / out_ready     square_size, top_row, left_col
// cfg      input      cfg_write                 cfg_index, cfg_data
//
// one map cell per cycle sustained unless a map's last cell is held; a cell's square size is known
// in the cycle after its word is taken, bounded by the registered read of the line memory
// the result word is registered from stage one as the last cell of the map leaves it
// rst is synchronous; the line memory has no clear, row zero fills it first
// a map's last cell waits in its stage only while an older result is still unread
module largest_empty_square_finder_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lesf_pkg::CharW-1:0]    cell_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lesf_pkg::SizeW-1:0]    square_size,
  output logic [lesf_pkg::RowW-1:0]     top_row,
  output logic [lesf_pkg::ColW-1:0]     left_col,
  input  logic                          cfg_write,
  input  logic [lesf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [lesf_pkg::CfgDataW-1:0] cfg_data
);

  logic [lesf_pkg::CharW-1:0] obstacle_char;
  logic [lesf_pkg::LenW-1:0]  row_length;
  logic [lesf_pkg::CntW-1:0]  row_count;

  logic [lesf_pkg::LenW-1:0] len_eff;
  logic [lesf_pkg::CntW-1:0] rows_eff;

  logic [lesf_pkg::ColW-1:0] col;
  logic [lesf_pkg::RowW-1:0] row;
  logic                      row_end;
  logic                      map_end;
  logic                      in_accept;

  logic                       s1_valid;
  logic [lesf_pkg::CharW-1:0] s1_char;
  logic [lesf_pkg::ColW-1:0]  s1_col;
  logic [lesf_pkg::RowW-1:0]  s1_row;
  logic                       s1_row_end;
  logic                       s1_map_end;
  logic                       s1_adv;

  logic [lesf_pkg::SizeW-1:0] line_mem [lesf_pkg::MaxCols];
  logic [lesf_pkg::SizeW-1:0] upper_size;

  logic [lesf_pkg::SizeW-1:0] left_size;
  logic [lesf_pkg::SizeW-1:0] diagonal_size;
  logic [lesf_pkg::SizeW-1:0] best_size;
  logic [lesf_pkg::RowW-1:0]  best_corner_row;
  logic [lesf_pkg::ColW-1:0]  best_corner_col;

  logic [lesf_pkg::SizeW-1:0] min_lu;
  logic [lesf_pkg::SizeW-1:0] min_all;
  logic [lesf_pkg::SizeW-1:0] cur;
  logic [lesf_pkg::CntW-1:0]  row_plus;
  logic [lesf_pkg::SizeW-1:0] col_plus;
  logic                       take_best;
  logic [lesf_pkg::SizeW-1:0] best_size_next;
  logic [lesf_pkg::RowW-1:0]  best_corner_row_next;
  logic [lesf_pkg::ColW-1:0]  best_corner_col_next;

  // config registers; the empty byte has no effect, any non-obstacle byte is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_char <= lesf_pkg::ObstacleReset;
      row_length    <= lesf_pkg::LenReset;
      row_count     <= lesf_pkg::CntReset;
    end else if (cfg_write) begin
      unique case (lesf_pkg::cfg_index_t'(cfg_index))
        lesf_pkg::CfgEmptyChar:    ;
        lesf_pkg::CfgObstacleChar: obstacle_char <= cfg_data[lesf_pkg::CharW-1:0];
        lesf_pkg::CfgRowLength:    row_length    <= cfg_data[lesf_pkg::LenW-1:0];
        lesf_pkg::CfgRowCount:     row_count     <= cfg_data;
        default:                   ;
      endcase
    end
  end

  always_comb begin
    if (row_length == '0) begin
      len_eff = lesf_pkg::LenW'(1);
    end else if (row_length > lesf_pkg::LenW'(lesf_pkg::MaxCols)) begin
      len_eff = lesf_pkg::LenW'(lesf_pkg::MaxCols);
    end else begin
      len_eff = row_length;
    end
    if (row_count == '0) begin
      rows_eff = lesf_pkg::CntW'(1);
    end else if (row_count > lesf_pkg::CntW'(lesf_pkg::MaxRows)) begin
      rows_eff = lesf_pkg::CntW'(lesf_pkg::MaxRows);
    end else begin
      rows_eff = row_count;
    end
  end

  // position of the incoming cell
  assign row_end   = ({1'b0, col} + lesf_pkg::LenW'(1)) >= len_eff;
  assign map_end   = row_end && (({1'b0, row} + lesf_pkg::CntW'(1)) >= rows_eff);
  assign s1_adv    = s1_valid && !(s1_map_end && out_valid && !out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        if (map_end) begin
          col <= '0;
          row <= '0;
        end else if (row_end) begin
          col <= '0;
          row <= row + lesf_pkg::RowW'(1);
        end else begin
          col <= col + lesf_pkg::ColW'(1);
        end
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_char    <= cell_char;
      s1_col     <= col;
      s1_row     <= row;
      s1_row_end <= row_end;
      s1_map_end <= map_end;
    end
  end

  // line memory: the read for a column comes a full row after its write,
  // a single-column row never uses the upper value
  always_ff @(posedge clk) begin
    if (in_accept) begin
      upper_size <= line_mem[col];
    end
    if (s1_adv) begin
      line_mem[s1_col] <= cur;
    end
  end

  // square size at the cell in stage one
  always_comb begin
    min_lu  = (left_size < upper_size) ? left_size : upper_size;
    min_all = (min_lu < diagonal_size) ? min_lu : diagonal_size;
    if (s1_char == obstacle_char) begin
      cur = '0;
    end else if (s1_row == '0 || s1_col == '0) begin
      cur = lesf_pkg::SizeW'(1);
    end else begin
      cur = min_all + lesf_pkg::SizeW'(1);
    end
    row_plus  = {1'b0, s1_row} + lesf_pkg::CntW'(1);
    col_plus  = {1'b0, s1_col} + lesf_pkg::SizeW'(1);
    take_best = (cur > best_size) && (lesf_pkg::CntW'(cur) <= row_plus) && (cur <= col_plus);
    if (take_best) begin
      best_size_next       = cur;
      best_corner_row_next = lesf_pkg::RowW'(row_plus - lesf_pkg::CntW'(cur));
      best_corner_col_next = lesf_pkg::ColW'(col_plus - cur);
    end else begin
      best_size_next       = best_size;
      best_corner_row_next = best_corner_row;
      best_corner_col_next = best_corner_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_size       <= '0;
      diagonal_size   <= '0;
      best_size       <= '0;
      best_corner_row <= '0;
      best_corner_col <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (s1_adv && s1_map_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s1_adv) begin
        if (s1_row_end) begin
          left_size     <= '0;
          diagonal_size <= '0;
        end else begin
          left_size     <= cur;
          diagonal_size <= upper_size;
        end
        if (s1_map_end) begin
          best_size       <= '0;
          best_corner_row <= '0;
          best_corner_col <= '0;
        end else begin
          best_size       <= best_size_next;
          best_corner_row <= best_corner_row_next;
          best_corner_col <= best_corner_col_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_map_end) begin
      square_size <= best_size_next;
      top_row     <= best_corner_row_next;
      left_col    <= best_corner_col_next;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_map_end && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while last cell is stalled");

  a_map_end_clears_best: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_map_end) |=> (best_size == '0 && out_valid))
    else $error("best square not cleared at end of map");

  a_row_end_clears_neighbors: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_row_end) |=> (left_size == '0 && diagonal_size == '0))
    else $error("neighbor sizes not cleared at end of row");

endmodule

>>> test/tb_largest_empty_square_finder_top.sv
`timescale 1ns / 1ps

module tb_largest_empty_square_finder_top;

  localparam int RandomCells = 550;
  localparam int CycleLimit = 4_000_000;

  typedef struct packed {
    logic [lesf_pkg::SizeW-1:0] size;
    logic [lesf_pkg::RowW-1:0]  top;
    logic [lesf_pkg::ColW-1:0]  left;
  } square_t;

  typedef enum logic [1:0] {
    FillSame,
    FillHole,
    FillRandom
  } fill_t;

  typedef struct packed {
    bit                         wr;
    logic [lesf_pkg::CharW-1:0] empty_b;
    logic [lesf_pkg::CharW-1:0] obst;
    logic [lesf_pkg::LenW-1:0]  len;
    logic [lesf_pkg::CntW-1:0]  cnt;
    fill_t                      fill;
    logic [lesf_pkg::CharW-1:0] fill_b;
    int                         hole;
    int                         dens;
    bit                         typed;
    square_t                    want;
  } map_case_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [lesf_pkg::CharW-1:0]    cell_char;
  logic                          out_valid;
  logic                          out_ready;
  logic [lesf_pkg::SizeW-1:0]    square_size;
  logic [lesf_pkg::RowW-1:0]     top_row;
  logic [lesf_pkg::ColW-1:0]     left_col;
  logic                          cfg_write;
  logic [lesf_pkg::CfgIdxW-1:0]  cfg_index;
  logic [lesf_pkg::CfgDataW-1:0] cfg_data;

  logic [lesf_pkg::CharW-1:0] reg_empty;
  logic [lesf_pkg::CharW-1:0] reg_obst;
  logic [lesf_pkg::LenW-1:0]  reg_len;
  logic [lesf_pkg::CntW-1:0]  reg_cnt;
  logic [lesf_pkg::SizeW-1:0] line_sizes [lesf_pkg::MaxCols];
  logic [lesf_pkg::SizeW-1:0] left_sz;
  logic [lesf_pkg::SizeW-1:0] diag_sz;
  logic [lesf_pkg::SizeW-1:0] best_sz;
  logic [lesf_pkg::ColW-1:0]  col_pos;
  logic [lesf_pkg::ColW-1:0]  best_col;
  logic [lesf_pkg::RowW-1:0]  row_pos;
  logic [lesf_pkg::RowW-1:0]  best_row;

  square_t pending_squares [$];
  int mismatches = 0;
  int cycles = 0;
  bit tx_hurry = 1'b0;
  bit rx_hurry = 1'b0;

  map_case_t plan [0:8] = '{
    '{1'b0, 8'h2E, 8'h6F, 11'd1024, 17'd1, FillHole, 8'h2E, 700, 0, 1'b1,
      '{11'd1, 16'd0, 10'd700}},
    '{1'b1, 8'h00, 8'h6F, 11'd1, 17'd1, FillSame, 8'h00, 0, 0, 1'b1,
      '{11'd1, 16'd0, 10'd0}},
    '{1'b1, 8'hFF, 8'h6F, 11'd1, 17'd1, FillSame, 8'h6F, 0, 0, 1'b1,
      '{11'd0, 16'd0, 10'd0}},
    '{1'b1, 8'h2E, 8'h00, 11'd0, 17'd0, FillSame, 8'hFF, 0, 0, 1'b1,
      '{11'd1, 16'd0, 10'd0}},
    '{1'b1, 8'h2E, 8'h00, 11'd2, 17'd2, FillSame, 8'h00, 0, 0, 1'b1,
      '{11'd0, 16'd0, 10'd0}},
    '{1'b1, 8'h2E, 8'hFF, 11'd2, 17'd2, FillSame, 8'h41, 0, 0, 1'b1,
      '{11'd2, 16'd0, 10'd0}},
    '{1'b1, 8'h00, 8'hFF, 11'd3, 17'd3, FillHole, 8'h00, 8, 0, 1'b1,
      '{11'd1, 16'd2, 10'd2}},
    '{1'b1, 8'h2E, 8'h6F, 11'd4, 17'd1, FillSame, 8'h2E, 0, 0, 1'b1,
      '{11'd1, 16'd0, 10'd0}},
    '{1'b1, 8'h80, 8'h6F, 11'd3, 17'd2, FillRandom, 8'h00, 0, 30, 1'b0, '0}
  };

  largest_empty_square_finder_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cell_char  (cell_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .square_size(square_size),
    .top_row    (top_row),
    .left_col   (left_col),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int eff_len();
    if (reg_len == 0) return 1;
    if (reg_len > lesf_pkg::MaxCols) return int'(lesf_pkg::MaxCols);
    return int'(reg_len);
  endfunction

  function automatic int eff_rows();
    if (reg_cnt == 0) return 1;
    if (reg_cnt > lesf_pkg::MaxRows) return int'(lesf_pkg::MaxRows);
    return int'(reg_cnt);
  endfunction

  function automatic void clear_map();
    left_sz  = '0;
    diag_sz  = '0;
    col_pos  = '0;
    row_pos  = '0;
    best_sz  = '0;
    best_row = '0;
    best_col = '0;
  endfunction

  function automatic bit track_square(input logic [lesf_pkg::CharW-1:0] c,
                                      output square_t res);
    int  col;
    int  row;
    int  upper;
    int  cur;
    int  m;
    bit  row_end;
    bit  map_end;
    col = int'(col_pos);
    row = int'(row_pos);
    upper = int'(line_sizes[col_pos]);
    row_end = col + 1 >= eff_len();
    map_end = row_end && row + 1 >= eff_rows();
    if (c == reg_obst) begin
      cur = 0;
    end else if (row == 0 || col == 0) begin
      cur = 1;
    end else begin
      m = int'(left_sz) < upper ? int'(left_sz) : upper;
      if (int'(diag_sz) < m) m = int'(diag_sz);
      cur = int'(lesf_pkg::SizeW'(m + 1));
    end
    if (cur > int'(best_sz) && cur <= row + 1 && cur <= col + 1) begin
      best_sz  = lesf_pkg::SizeW'(cur);
      best_row = lesf_pkg::RowW'(row + 1 - cur);
      best_col = lesf_pkg::ColW'(col + 1 - cur);
    end
    line_sizes[col_pos] = lesf_pkg::SizeW'(cur);
    diag_sz = lesf_pkg::SizeW'(upper);
    left_sz = lesf_pkg::SizeW'(cur);
    res = '0;
    if (map_end) begin
      res.size = best_sz;
      if (best_sz != 0) begin
        res.top  = best_row;
        res.left = best_col;
      end
      clear_map();
      return 1'b1;
    end
    if (row_end) begin
      col_pos = '0;
      row_pos = row_pos + lesf_pkg::RowW'(1);
      left_sz = '0;
      diag_sz = '0;
    end else begin
      col_pos = col_pos + lesf_pkg::ColW'(1);
    end
    return 1'b0;
  endfunction

  task automatic push_cell(input logic [lesf_pkg::CharW-1:0] c, input bit typed,
                           input square_t want);
    int gap;
    square_t got;
    gap = tx_hurry ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    cell_char <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (track_square(c, got)) pending_squares.push_back(typed ? want : got);
  endtask

  task automatic idle_pause();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_squares.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_regs(input logic [lesf_pkg::CharW-1:0] e,
                           input logic [lesf_pkg::CharW-1:0] o,
                           input logic [lesf_pkg::LenW-1:0] l,
                           input logic [lesf_pkg::CntW-1:0] n);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= lesf_pkg::CfgEmptyChar;
    cfg_data  <= lesf_pkg::CfgDataW'(e);
    @(negedge clk);
    cfg_index <= lesf_pkg::CfgObstacleChar;
    cfg_data  <= lesf_pkg::CfgDataW'(o);
    @(negedge clk);
    cfg_index <= lesf_pkg::CfgRowLength;
    cfg_data  <= lesf_pkg::CfgDataW'(l);
    @(negedge clk);
    cfg_index <= lesf_pkg::CfgRowCount;
    cfg_data  <= lesf_pkg::CfgDataW'(n);
    @(negedge clk);
    cfg_write <= 1'b0;
    reg_empty = e;
    reg_obst  = o;
    reg_len   = l;
    reg_cnt   = n;
  endtask

  task automatic send_map(input map_case_t m, output int cells);
    int i;
    logic [lesf_pkg::CharW-1:0] c;
    if (m.wr) begin
      idle_pause();
      load_regs(m.empty_b, m.obst, m.len, m.cnt);
    end
    cells = eff_len() * eff_rows();
    for (i = 0; i < cells; i++) begin
      case (m.fill)
        FillSame: c = m.fill_b;
        FillHole: c = (i == m.hole) ? m.fill_b : reg_obst;
        default: begin
          if ($urandom_range(0, 99) < m.dens) c = reg_obst;
          else if ($urandom_range(0, 3) == 0) c = reg_empty;
          else c = lesf_pkg::CharW'($urandom);
        end
      endcase
      push_cell(c, m.typed, m.want);
    end
  endtask

  // result word side: random stall after every accepted word, none while rx_hurry is set
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = rx_hurry ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_result
    square_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_squares.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: size %0d row %0d col %0d",
                   square_size, top_row, left_col);
      end else begin
        want = pending_squares.pop_front();
        if (square_size !== want.size || top_row !== want.top || left_col !== want.left) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: want size %0d row %0d col %0d, %s %0d row %0d col %0d",
                     $time, want.size, want.top, want.left, "got size",
                     square_size, top_row, left_col);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int k;
    int j;
    int n;
    int nmaps;
    int random_cells;
    bit tiny;
    map_case_t m;
    rst       = 1'b1;
    in_valid  = 1'b0;
    cell_char = '0;
    cfg_write = 1'b0;
    cfg_index = lesf_pkg::CfgEmptyChar;
    cfg_data  = '0;
    reg_empty = 8'd46;
    reg_obst  = lesf_pkg::ObstacleReset;
    reg_len   = lesf_pkg::LenReset;
    reg_cnt   = lesf_pkg::CntReset;
    for (k = 0; k < int'(lesf_pkg::MaxCols); k++) line_sizes[k] = '0;
    clear_map();
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < 9; k++) send_map(plan[k], n);

    random_cells = 0;
    while (random_cells < RandomCells) begin
      tiny = $urandom_range(0, 3) == 0;
      m = '0;
      m.wr      = 1'b1;
      m.empty_b = lesf_pkg::CharW'($urandom);
      case ($urandom_range(0, 7))
        0: m.obst = 8'h00;
        1: m.obst = 8'hFF;
        default: m.obst = lesf_pkg::CharW'($urandom);
      endcase
      if (tiny) begin
        m.len = lesf_pkg::LenW'($urandom_range(0, 2));
        m.cnt = lesf_pkg::CntW'($urandom_range(0, 2));
      end else begin
        m.len = ($urandom_range(0, 15) == 0) ? lesf_pkg::LenW'($urandom_range(11, 40))
                                             : lesf_pkg::LenW'($urandom_range(0, 10));
        m.cnt = lesf_pkg::CntW'($urandom_range(0, 8));
      end
      m.fill = FillRandom;
      tx_hurry = $urandom_range(0, 3) == 0;
      rx_hurry = $urandom_range(0, 3) == 0;
      nmaps = $urandom_range(1, 4);
      for (j = 0; j < nmaps; j++) begin
        m.dens = $urandom_range(0, 60);
        send_map(m, n);
        m.wr = 1'b0;
        random_cells += n;
      end
    end

    idle_pause();
    repeat (20) @(posedge clk);
    mismatches += pending_squares.size();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
